>>> rtl/length_prefixed_message_deframer_top_macros.svh
// assertion macros for the length-prefixed message deframer
// used by length_prefixed_message_deframer_top, expects clk and rst_n in scope
`ifndef LENGTH_PREFIXED_MESSAGE_DEFRAMER_TOP_MACROS_SVH
`define LENGTH_PREFIXED_MESSAGE_DEFRAMER_TOP_MACROS_SVH

// same-cycle implication
`define LPMD_ASSERT_IMP(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define LPMD_ASSERT_NXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/lpmd_pkg.sv
// shared types and constants for the length-prefixed message deframer
// no dependencies
package lpmd_pkg;

  typedef enum logic [2:0] {
    PH_FLAG = 3'd0,
    PH_ILEN = 3'd1,
    PH_PLEN = 3'd2,
    PH_INFO = 3'd3,
    PH_PAY  = 3'd4
  } phase_t;

  localparam logic [1:0] KIND_HEADER  = 2'd0;
  localparam logic [1:0] KIND_INFO    = 2'd1;
  localparam logic [1:0] KIND_PAYLOAD = 2'd2;

  localparam logic [1:0] LAST_FIELD_BYTE = 2'd3;

  typedef struct packed {
    logic [1:0] byte_kind;
    logic [7:0] byte_value;
    logic       info_done;
    logic       message_done;
    logic       payload_present;
    logic       length_error;
  } out_item_t;

endpackage

>>> rtl/lpmd_core.sv
// parse state and per-byte tagging logic of the deframer
// depends on lpmd_pkg
module lpmd_core import lpmd_pkg::*; #(
  parameter int LEN_BITS = 32
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      accept,
  input  logic [7:0] rx_byte,
  output out_item_t item,
  output phase_t    phase
);

  phase_t                phase_r, phase_nxt;
  logic [1:0]            fbi_r, fbi_nxt;
  logic [23:0]           shift_r, shift_nxt;
  logic                  pflag_r, pflag_nxt;
  logic [LEN_BITS-1:0]   info_rem_r, info_rem_nxt;
  logic [LEN_BITS-1:0]   pay_rem_r, pay_rem_nxt;

  logic [30:0]           len_raw;
  logic [LEN_BITS-1:0]   len_sat;
  logic [LEN_BITS-1:0]   len;
  logic [LEN_BITS-1:0]   info_dec;
  logic [LEN_BITS-1:0]   pay_dec;

  assign len_raw = {rx_byte[6:0], shift_r};

  generate
    if (LEN_BITS >= 31) begin : g_nosat
      assign len_sat = LEN_BITS'(len_raw);
    end else begin : g_sat
      assign len_sat = (|len_raw[30:LEN_BITS]) ? '1 : len_raw[LEN_BITS-1:0];
    end
  endgenerate

  // negative length counts as zero
  assign len      = rx_byte[7] ? '0 : len_sat;
  assign info_dec = (info_rem_r != '0) ? info_rem_r - LEN_BITS'(1) : '0;
  assign pay_dec  = (pay_rem_r != '0) ? pay_rem_r - LEN_BITS'(1) : '0;

  always_comb begin
    phase_nxt         = phase_r;
    fbi_nxt           = fbi_r;
    shift_nxt         = shift_r;
    pflag_nxt         = pflag_r;
    info_rem_nxt      = info_rem_r;
    pay_rem_nxt       = pay_rem_r;
    item.byte_kind    = KIND_HEADER;
    item.byte_value   = rx_byte;
    item.info_done    = 1'b0;
    item.message_done = 1'b0;
    item.length_error = 1'b0;
    unique case (phase_r)
      PH_ILEN, PH_PLEN: begin
        if (fbi_r != LAST_FIELD_BYTE) begin
          shift_nxt = shift_r | (24'(rx_byte) << {fbi_r, 3'b000});
          fbi_nxt   = fbi_r + 2'd1;
        end else begin
          item.length_error = rx_byte[7];
          fbi_nxt           = 2'd0;
          shift_nxt         = '0;
          if (phase_r == PH_ILEN) begin
            info_rem_nxt = len;
            if (pflag_r) begin
              phase_nxt = PH_PLEN;
            end else if (len == '0) begin
              item.info_done    = 1'b1;
              item.message_done = 1'b1;
              phase_nxt         = PH_FLAG;
            end else begin
              phase_nxt = PH_INFO;
            end
          end else begin
            pay_rem_nxt = len;
            if (info_rem_r != '0) begin
              phase_nxt = PH_INFO;
            end else begin
              item.info_done = 1'b1;
              if (len == '0) begin
                item.message_done = 1'b1;
                phase_nxt         = PH_FLAG;
              end else begin
                phase_nxt = PH_PAY;
              end
            end
          end
        end
      end
      PH_INFO: begin
        item.byte_kind = KIND_INFO;
        info_rem_nxt   = info_dec;
        if (info_dec == '0) begin
          item.info_done = 1'b1;
          if (pflag_r && (pay_rem_r != '0)) begin
            phase_nxt = PH_PAY;
          end else begin
            item.message_done = 1'b1;
            phase_nxt         = PH_FLAG;
          end
        end
      end
      PH_PAY: begin
        item.byte_kind = KIND_PAYLOAD;
        pay_rem_nxt    = pay_dec;
        if (pay_dec == '0) begin
          item.message_done = 1'b1;
          phase_nxt         = PH_FLAG;
        end
      end
      default: begin
        pflag_nxt    = |rx_byte;
        info_rem_nxt = '0;
        pay_rem_nxt  = '0;
        fbi_nxt      = 2'd0;
        shift_nxt    = '0;
        phase_nxt    = PH_ILEN;
      end
    endcase
    item.payload_present = pflag_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= PH_FLAG;
      fbi_r      <= 2'd0;
      shift_r    <= '0;
      pflag_r    <= 1'b0;
      info_rem_r <= '0;
      pay_rem_r  <= '0;
    end else if (accept) begin
      phase_r    <= phase_nxt;
      fbi_r      <= fbi_nxt;
      shift_r    <= shift_nxt;
      pflag_r    <= pflag_nxt;
      info_rem_r <= info_rem_nxt;
      pay_rem_r  <= pay_rem_nxt;
    end
  end

  assign phase = phase_r;

endmodule

>>> rtl/lpmd_out_buf.sv
// two-entry result register with skid entry, decouples in_ready from out_ready
// depends on lpmd_pkg
module lpmd_out_buf import lpmd_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      push,
  input  out_item_t push_item,
  output logic      can_push,
  output logic      pop_valid,
  input  logic      pop_ready,
  output out_item_t pop_item
);

  out_item_t  mem_r [2];
  logic       wr_ptr_r;
  logic       rd_ptr_r;
  logic [1:0] cnt_r, cnt_nxt;
  logic       pop;

  assign can_push  = (cnt_r != 2'd2);
  assign pop_valid = (cnt_r != 2'd0);
  assign pop       = pop_valid && pop_ready;
  assign pop_item  = mem_r[rd_ptr_r];

  always_comb begin
    cnt_nxt = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + 2'd1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr_r <= ~wr_ptr_r;
      end
      if (pop) begin
        rd_ptr_r <= ~rd_ptr_r;
      end
      cnt_r <= cnt_nxt;
    end
  end

endmodule

>>> rtl/length_prefixed_message_deframer_top.sv
// Splits a byte stream into length-prefixed messages and tags every byte
// (header, info or payload) with end-of-info and end-of-message marks.
// One byte is accepted per clock while in_ready is high; each parse
// result is registered in the two-entry output buffer before it reaches
// the outputs. in_ready drops only while both buffer entries hold results
// not yet taken.
// depends on lpmd_pkg, lpmd_core, lpmd_out_buf and the macros header
`include "length_prefixed_message_deframer_top_macros.svh"

module length_prefixed_message_deframer_top import lpmd_pkg::*; #(
  parameter int LEN_BITS = 32
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_rx_byte,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [1:0] out_byte_kind,
  output logic [7:0] out_byte_value,
  output logic       out_info_done,
  output logic       out_message_done,
  output logic       out_payload_present,
  output logic       out_length_error
);

  logic      accept;
  out_item_t core_item;
  out_item_t buf_item;
  phase_t    phase;
  logic      out_err;
  logic      out_is_info;
  logic      out_is_pay;
  logic      flag_take;

  assign accept = in_valid && in_ready;

  lpmd_core #(
    .LEN_BITS (LEN_BITS)
  ) u_core (
    .clk     (clk),
    .rst_n   (rst_n),
    .accept  (accept),
    .rx_byte (in_rx_byte),
    .item    (core_item),
    .phase   (phase)
  );

  lpmd_out_buf u_out_buf (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (accept),
    .push_item (core_item),
    .can_push  (in_ready),
    .pop_valid (out_valid),
    .pop_ready (out_ready),
    .pop_item  (buf_item)
  );

  assign out_byte_kind       = buf_item.byte_kind;
  assign out_byte_value      = buf_item.byte_value;
  assign out_info_done       = buf_item.info_done;
  assign out_message_done    = buf_item.message_done;
  assign out_payload_present = buf_item.payload_present;
  assign out_length_error    = buf_item.length_error;

  assign out_err     = out_valid && out_length_error;
  assign out_is_info = out_valid && (out_byte_kind == KIND_INFO);
  assign out_is_pay  = out_valid && (out_byte_kind == KIND_PAYLOAD);
  assign flag_take   = accept && (phase == PH_FLAG);

  `LPMD_ASSERT_IMP(a_err_hdr, out_err, out_byte_kind == KIND_HEADER, "error off header")
  `LPMD_ASSERT_IMP(a_pay_has_flag, out_is_pay, out_payload_present, "payload byte without flag")
  `LPMD_ASSERT_IMP(a_info_end, out_is_info && out_message_done, out_info_done, "info open at end")
  `LPMD_ASSERT_NXT(a_flag_to_ilen, flag_take, phase == PH_ILEN, "no length after flag")

endmodule

>>> dv/tb_length_prefixed_message_deframer_top.sv
// testbench for length_prefixed_message_deframer_top: byte streams of framed messages
// checked against a built-in parser model; depends on lpmd_pkg and the rtl top level
module tb_length_prefixed_message_deframer_top;
  import lpmd_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int LEN_BITS = 32;
  localparam logic [63:0] MAX_LEN = (64'd1 << LEN_BITS) - 64'd1;
  localparam int CYCLE_LIMIT = 1000000;
  localparam int RANDOM_ITEMS = 900;
  localparam int STREAM_ITEMS = 300;
  localparam logic [31:0] LONG_INFO_LEN = 32'h0000_0105;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_ready;
  logic [7:0] in_rx_byte = 8'd0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic [1:0] out_byte_kind;
  logic [7:0] out_byte_value;
  logic       out_info_done;
  logic       out_message_done;
  logic       out_payload_present;
  logic       out_length_error;

  // parser state of the model
  phase_t      cur_phase = PH_FLAG;
  logic [1:0]  field_idx = '0;
  logic [23:0] len_low = '0;
  logic        has_payload = 1'b0;
  logic [31:0] info_left = '0;
  logic [31:0] pay_left = '0;

  out_item_t expected_bytes[$];

  bit idle_on = 1'b0;
  int stall_left = 0;
  int cycles = 0;
  int mismatches = 0;
  int bytes_sent = 0;
  int bytes_checked = 0;
  int messages_done = 0;
  int length_errors_seen = 0;

  length_prefixed_message_deframer_top #(.LEN_BITS(LEN_BITS)) dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_rx_byte         (in_rx_byte),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_byte_kind      (out_byte_kind),
    .out_byte_value     (out_byte_value),
    .out_info_done      (out_info_done),
    .out_message_done   (out_message_done),
    .out_payload_present(out_payload_present),
    .out_length_error   (out_length_error)
  );

  always #1 clk = ~clk;

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycles,
               expected_bytes.size());
      $display("length_prefixed_message_deframer_top test failed");
      $finish;
    end
  end

  task automatic report_mismatch(input string what, input int got, input int want);
    mismatches++;
    if (mismatches <= 20) begin
      $display("mismatch at cycle %0d, result %0d: %s got %0d expected %0d",
               cycles, bytes_checked, what, got, want);
    end
  endtask

  task automatic predict_byte(input logic [7:0] b);
    out_item_t   r;
    logic [31:0] len;
    logic [63:0] full;
    r = '0;
    r.byte_kind = KIND_HEADER;
    r.byte_value = b;
    len = '0;
    case (cur_phase)
      PH_ILEN, PH_PLEN: begin
        if (field_idx != LAST_FIELD_BYTE) begin
          len_low = len_low | (24'(b) << (8 * field_idx));
          field_idx = field_idx + 2'd1;
        end else begin
          if (b[7]) begin
            r.length_error = 1'b1;
          end else begin
            full = {32'd0, b, len_low};
            if (full > MAX_LEN) full = MAX_LEN;
            len = full[31:0];
          end
          field_idx = '0;
          len_low = '0;
          if (cur_phase == PH_ILEN) begin
            info_left = len;
            if (has_payload) begin
              cur_phase = PH_PLEN;
            end else if (len == 0) begin
              r.info_done = 1'b1;
              r.message_done = 1'b1;
              cur_phase = PH_FLAG;
            end else begin
              cur_phase = PH_INFO;
            end
          end else begin
            pay_left = len;
            if (info_left != 0) begin
              cur_phase = PH_INFO;
            end else begin
              r.info_done = 1'b1;
              if (len == 0) begin
                r.message_done = 1'b1;
                cur_phase = PH_FLAG;
              end else begin
                cur_phase = PH_PAY;
              end
            end
          end
        end
      end
      PH_INFO: begin
        r.byte_kind = KIND_INFO;
        if (info_left != 0) info_left = info_left - 32'd1;
        if (info_left == 0) begin
          r.info_done = 1'b1;
          if (has_payload && pay_left != 0) begin
            cur_phase = PH_PAY;
          end else begin
            r.message_done = 1'b1;
            cur_phase = PH_FLAG;
          end
        end
      end
      PH_PAY: begin
        r.byte_kind = KIND_PAYLOAD;
        if (pay_left != 0) pay_left = pay_left - 32'd1;
        if (pay_left == 0) begin
          r.message_done = 1'b1;
          cur_phase = PH_FLAG;
        end
      end
      default: begin
        has_payload = (b != 8'd0);
        info_left = '0;
        pay_left = '0;
        field_idx = '0;
        len_low = '0;
        cur_phase = PH_ILEN;
      end
    endcase
    r.payload_present = has_payload;
    expected_bytes.push_back(r);
  endtask

  // result checker
  always @(posedge clk) begin
    out_item_t want;
    if (rst_n && out_valid && out_ready) begin
      if (expected_bytes.size() == 0) begin
        report_mismatch("unexpected result, byte_value", out_byte_value, -1);
      end else begin
        want = expected_bytes.pop_front();
        if (out_byte_kind != want.byte_kind)
          report_mismatch("byte_kind", out_byte_kind, want.byte_kind);
        if (out_byte_value != want.byte_value)
          report_mismatch("byte_value", out_byte_value, want.byte_value);
        if (out_info_done != want.info_done)
          report_mismatch("info_done", out_info_done, want.info_done);
        if (out_message_done != want.message_done)
          report_mismatch("message_done", out_message_done, want.message_done);
        if (out_payload_present != want.payload_present)
          report_mismatch("payload_present", out_payload_present, want.payload_present);
        if (out_length_error != want.length_error)
          report_mismatch("length_error", out_length_error, want.length_error);
      end
      bytes_checked++;
      if (out_message_done) messages_done++;
      if (out_length_error) length_errors_seen++;
    end
  end

  // receiver stalls
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      out_ready <= (stall_left == 0);
    end else if (idle_on && $urandom_range(0, 5) == 0) begin
      stall_left = $urandom_range(1, 11);
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  task automatic send_byte(input logic [7:0] b);
    int gap;
    if (idle_on && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 11);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_rx_byte <= b;
    predict_byte(b);
    bytes_sent++;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic send_message(input logic [7:0] flag, input logic [31:0] info_len,
                              input logic [31:0] pay_len);
    int n_body;
    send_byte(flag);
    for (int i = 0; i < 4; i++) send_byte(info_len[8*i +: 8]);
    if (flag != 8'd0) begin
      for (int i = 0; i < 4; i++) send_byte(pay_len[8*i +: 8]);
    end
    n_body = info_len[31] ? 0 : int'(info_len);
    if (flag != 8'd0 && !pay_len[31]) n_body += int'(pay_len);
    repeat (n_body) send_byte(8'($urandom_range(0, 255)));
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (expected_bytes.size() != 0) @(posedge clk);
  endtask

  function automatic logic [31:0] pick_length();
    int sel;
    sel = $urandom_range(0, 19);
    if (sel < 3) return 32'd0;
    if (sel < 5) return 32'h8000_0000 | 32'($urandom);
    if (sel == 5) return 32'($urandom_range(100, 300));
    return 32'($urandom_range(1, 8));
  endfunction

  function automatic logic [7:0] pick_flag();
    if ($urandom_range(0, 2) == 0) return 8'd0;
    return 8'($urandom_range(1, 255));
  endfunction

  task automatic send_random_message();
    send_message(pick_flag(), pick_length(), pick_length());
  endtask

  task automatic test_empty_messages();
    send_message(8'h00, 32'd0, 32'd0);
    send_message(8'hFF, 32'd0, 32'd0);
  endtask

  task automatic test_negative_lengths();
    send_message(8'h00, 32'hFFFF_FFFF, 32'd0);
    send_message(8'h80, 32'd1, 32'h8000_0001);
  endtask

  task automatic test_section_skips();
    send_message(8'h01, 32'd0, 32'd2);
    send_message(8'h00, 32'd1, 32'd0);
  endtask

  task automatic test_random_traffic();
    int start;
    idle_on = 1'b1;
    start = bytes_sent;
    while (bytes_sent - start < RANDOM_ITEMS / 2) send_random_message();
    wait_drained();
    repeat ($urandom_range(1, 11)) @(posedge clk);
    while (bytes_sent - start < RANDOM_ITEMS) send_random_message();
  endtask

  task automatic test_streaming_no_idle();
    int start;
    idle_on = 1'b0;
    start = bytes_sent;
    while (bytes_sent - start < STREAM_ITEMS) send_random_message();
    send_message(8'h5A, LONG_INFO_LEN, 32'd3);
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_empty_messages();
    test_negative_lengths();
    test_section_skips();
    test_random_traffic();
    test_streaming_no_idle();
    wait_drained();
    repeat (8) @(posedge clk);
    $display("sent %0d bytes, checked %0d results over %0d messages", bytes_sent,
             bytes_checked, messages_done);
    $display("%0d length fields flagged negative, %0d mismatches", length_errors_seen,
             mismatches);
    if (mismatches == 0 && expected_bytes.size() == 0) begin
      $display("length_prefixed_message_deframer_top test passed");
    end else begin
      $display("length_prefixed_message_deframer_top test failed");
    end
    $finish;
  end

endmodule

>>> sim.f
+incdir+rtl
rtl/lpmd_pkg.sv
rtl/lpmd_core.sv
rtl/lpmd_out_buf.sv
rtl/length_prefixed_message_deframer_top.sv
dv/tb_length_prefixed_message_deframer_top.sv
